FILE: hdl/sha_pkg.sv
`default_nettype none

package sha_pkg;

    typedef enum logic [2:0] {
        SRC_DATA,
        SRC_PAD80,
        SRC_ZERO,
        SRC_LEN_HI,
        SRC_LEN_LO
    } sha_src_t;

    typedef struct packed {
        logic       accept;
        logic       push;
        sha_src_t   src;
        logic       load_vars;
        logic       round;
        logic [5:0] rnd;
        logic       hash_add;
        logic       out_shift;
        logic       clear;
    } sha_cmd_t;

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;

    localparam logic [31:0] INITIAL_HASH [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

`default_nettype wire

FILE: hdl/sha_if.sv
`default_nettype none

interface sha_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] msg_word;
    logic [2:0]  valid_bytes;
    logic        last;

    modport source (output valid, output msg_word, output valid_bytes, output last,
                    input ready);
    modport sink   (input valid, input msg_word, input valid_bytes, input last,
                    output ready);
endinterface

interface sha_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;

    modport source (output valid, output digest_word, output word_index,
                    output digest_last, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input digest_last, output ready);
endinterface

`default_nettype wire

FILE: hdl/sha_ctrl.sv
`default_nettype none

module sha_ctrl
    import sha_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       msg_valid,
    input  wire logic       msg_last,
    input  wire logic [2:0] msg_bytes,
    output logic            msg_ready,
    output logic            digest_valid,
    input  wire logic       digest_ready,
    output logic [2:0]      word_index,
    output sha_cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_HADD,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] fill_reg, fill_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       pend80_reg, pend80_next;
    logic       lenhi_reg, lenhi_next;
    logic       padding_reg, padding_next;
    logic       done_reg, done_next;

    assign msg_ready    = (state_reg == ST_IDLE);
    assign digest_valid = (state_reg == ST_EMIT);
    assign word_index   = idx_reg;

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        rnd_next     = rnd_reg;
        idx_next     = idx_reg;
        pend80_next  = pend80_reg;
        lenhi_next   = lenhi_reg;
        padding_next = padding_reg;
        done_next    = done_reg;
        cmd          = '0;
        cmd.src      = SRC_DATA;
        cmd.rnd      = rnd_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    cmd.accept   = 1'b1;
                    cmd.push     = 1'b1;
                    cmd.src      = SRC_DATA;
                    fill_next    = fill_reg + 4'd1;
                    pend80_next  = msg_last && msg_bytes[2];
                    padding_next = msg_last;
                    if (fill_reg == 4'd15)
                    begin
                        rnd_next   = '0;
                        state_next = ST_ROUND;
                    end
                    else if (msg_last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.push  = 1'b1;
                fill_next = fill_reg + 4'd1;
                if (pend80_reg)
                begin
                    cmd.src     = SRC_PAD80;
                    pend80_next = 1'b0;
                end
                else if (fill_reg != 4'd14 && !lenhi_reg)
                begin
                    cmd.src = SRC_ZERO;
                end
                else if (!lenhi_reg)
                begin
                    cmd.src    = SRC_LEN_HI;
                    lenhi_next = 1'b1;
                end
                else
                begin
                    cmd.src   = SRC_LEN_LO;
                    done_next = 1'b1;
                end
                if (fill_reg == 4'd15)
                begin
                    rnd_next   = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_HADD;
                end
            end
            ST_HADD:
            begin
                cmd.hash_add = 1'b1;
                if (done_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
                else if (padding_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (digest_ready)
                begin
                    cmd.out_shift = 1'b1;
                    idx_next      = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.clear    = 1'b1;
                        done_next    = 1'b0;
                        padding_next = 1'b0;
                        lenhi_next   = 1'b0;
                        pend80_next  = 1'b0;
                        fill_next    = '0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        cmd.load_vars = cmd.push && (fill_reg == 4'd15);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            rnd_reg     <= '0;
            idx_reg     <= '0;
            pend80_reg  <= 1'b0;
            lenhi_reg   <= 1'b0;
            padding_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rnd_reg     <= rnd_next;
            idx_reg     <= idx_next;
            pend80_reg  <= pend80_next;
            lenhi_reg   <= lenhi_next;
            padding_reg <= padding_next;
            done_reg    <= done_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sha_datapath.sv
`default_nettype none

module sha_datapath
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sha_cmd_t    cmd,
    input  wire logic [31:0] msg_word,
    input  wire logic [2:0]  valid_bytes,
    input  wire logic        last,
    output logic [31:0]      digest_word
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] win_reg  [0:15];
    logic [31:0] v_reg    [0:7];
    logic [31:0] hash_reg [0:7];
    logic [63:0] len_reg;

    logic [31:0] padded_word;
    logic [31:0] push_word;
    logic [31:0] sched_word;
    logic [31:0] s0, s1;
    logic [31:0] big_s0, big_s1, ch, maj, t1, t2;
    logic [31:0] v_next [0:7];
    logic [2:0]  nb_sat;

    assign nb_sat = valid_bytes[2] ? 3'd4 : valid_bytes;

    // last partial word: keep the used top bytes and place the 0x80 byte after them
    always_comb
    begin
        unique case (valid_bytes)
            3'd0:    padded_word = PAD_WORD;
            3'd1:    padded_word = {msg_word[31:24], 24'h80_0000};
            3'd2:    padded_word = {msg_word[31:16], 16'h8000};
            3'd3:    padded_word = {msg_word[31:8], 8'h80};
            default: padded_word = msg_word;
        endcase
    end

    always_comb
    begin
        unique case (cmd.src)
            SRC_DATA:   push_word = last ? padded_word : msg_word;
            SRC_PAD80:  push_word = PAD_WORD;
            SRC_ZERO:   push_word = '0;
            SRC_LEN_HI: push_word = len_reg[63:32];
            SRC_LEN_LO: push_word = len_reg[31:0];
            default:    push_word = '0;
        endcase
    end

    assign s0 = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
    assign s1 = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
    assign sched_word = win_reg[0] + s0 + win_reg[9] + s1;

    assign big_s1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
    assign ch     = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1     = v_reg[7] + big_s1 + ch + ROUND_K[cmd.rnd] + win_reg[0];
    assign big_s0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
    assign maj    = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2     = big_s0 + maj;

    always_comb
    begin
        v_next[0] = t1 + t2;
        v_next[1] = v_reg[0];
        v_next[2] = v_reg[1];
        v_next[3] = v_reg[2];
        v_next[4] = v_reg[3] + t1;
        v_next[5] = v_reg[4];
        v_next[6] = v_reg[5];
        v_next[7] = v_reg[6];
    end

    // block window: words enter at the top; during rounds it is the schedule
    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= cmd.push ? push_word : sched_word;
        end
        if (cmd.load_vars)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= hash_reg[i];
            end
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= v_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= INITIAL_HASH[i];
            end
            len_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= INITIAL_HASH[i];
                end
                len_reg <= '0;
            end
            else
            begin
                if (cmd.hash_add)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                end
                else if (cmd.out_shift)
                begin
                    for (int i = 0; i < 7; i++)
                    begin
                        hash_reg[i] <= hash_reg[i + 1];
                    end
                    hash_reg[7] <= hash_reg[0];
                end
                if (cmd.accept)
                begin
                    len_reg <= len_reg + (last ? {58'd0, nb_sat, 3'd0} : 64'd32);
                end
            end
        end
    end

    assign digest_word = hash_reg[0];

endmodule

`default_nettype wire

FILE: hdl/sha256_hash_engine_core.sv
`default_nettype none

// Channel     Dir  Word fields
// msg_in      in   msg_word[31:0], valid_bytes[2:0], last
// digest_out  out  digest_word[31:0], word_index[2:0], digest_last
//
// A word that does not fill a block is only shifted into the window. The word
// that completes a 16-word block starts the 64 rounds on a single shared round
// unit, then a hash update. A last word adds padding words, one or two
// compressions, then 8 digest words, each held until taken. msg_in.ready is
// high only while idle. Reset loads the initial hash and clears length and fill.

module sha256_hash_engine_core
    import sha_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    sha_word_if.sink    msg_in,
    sha_digest_if.source digest_out
);

    sha_cmd_t   cmd;
    logic [2:0] word_index;

    sha_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_in.valid),
        .msg_last     (msg_in.last),
        .msg_bytes    (msg_in.valid_bytes),
        .msg_ready    (msg_in.ready),
        .digest_valid (digest_out.valid),
        .digest_ready (digest_out.ready),
        .word_index   (word_index),
        .cmd          (cmd)
    );

    sha_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .msg_word    (msg_in.msg_word),
        .valid_bytes (msg_in.valid_bytes),
        .last        (msg_in.last),
        .digest_word (digest_out.digest_word)
    );

    assign digest_out.word_index  = word_index;
    assign digest_out.digest_last = (word_index == 3'd7);

endmodule

`default_nettype wire
